// ----- rtl/bem2d_pkg.sv -----
// shared types, constants and constant tables for the 2d laplace boundary element block
// used by bem2d_front, bem2d_fifo, bem2d_back and the top level
package bem2d_pkg;

  localparam int COORD_FRAC_BITS  = 24;
  localparam int RESULT_FRAC_BITS = 20;
  localparam int ACC_FRAC         = 32;
  localparam int EXP_W            = 12;
  localparam int FIFO_DEPTH       = 2;
  localparam int PTR_W            = $clog2(FIFO_DEPTH);
  localparam int CNT_W            = $clog2(FIFO_DEPTH + 1);

  localparam logic [63:0] DEC_ONE = 64'd1000000000000000;

  // pseudo-float: normalized 32-bit mantissa times 2^e, with sign
  typedef struct packed {
    logic                    neg;
    logic signed [EXP_W-1:0] e;
    logic [31:0]             m;
  } pf_t;

  // classified pair handed from front end to back end
  typedef struct packed {
    logic [32:0]        udx;
    logic               dx_neg;
    logic [32:0]        udy;
    logic               dy_neg;
    logic signed [34:0] s2x;
    logic signed [34:0] s2y;
    logic               singular;
    logic               last;
  } desc_t;

  // floor(n * 2^bits / 10^15), elaboration only
  function automatic logic [63:0] dec_frac(input logic [63:0] n, input int bits);
    logic [63:0] rem;
    logic [63:0] q;
    rem = n;
    q   = '0;
    for (int i = 0; i < bits; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= DEC_ONE) begin
        rem  = rem - DEC_ONE;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // decimal fraction to normalized pseudo-float, elaboration only
  function automatic pf_t pf_const(input logic [63:0] dec);
    logic [63:0] q;
    int          e;
    pf_t         r;
    q = dec_frac(dec, 32);
    e = -32;
    for (int i = 0; i < 32; i++) begin
      if (q < 64'h8000_0000) begin
        q = q << 1;
        e = e - 1;
      end
    end
    r.neg = 1'b0;
    r.e   = EXP_W'(e);
    r.m   = q[31:0];
    return r;
  endfunction

  localparam pf_t LN2_PF    = pf_const(64'd693147180559945);
  localparam pf_t INV4PI_PF = pf_const(64'd79577471545948);
  localparam pf_t INV2PI_PF = pf_const(64'd159154943091895);

  localparam pf_t WEIGHT_PF [3] = '{
    pf_const(64'd171324492379170),
    pf_const(64'd360761573048139),
    pf_const(64'd467913934572691)
  };

  // gauss node magnitudes in q30
  localparam logic [29:0] NODE_Q [3] = '{
    30'(dec_frac(64'd932469514203152, 30)),
    30'(dec_frac(64'd661209386466265, 30)),
    30'(dec_frac(64'd238619186083197, 30))
  };

endpackage

// ----- rtl/bem2d_front.sv -----
// front end: takes pairs, forms differences and decides the singular case
// depends on bem2d_pkg; feeds the descriptor queue
module bem2d_front import bem2d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] seg_start_x,
  input  logic signed [31:0] seg_start_y,
  input  logic signed [31:0] seg_end_x,
  input  logic signed [31:0] seg_end_y,
  input  logic signed [31:0] field_x,
  input  logic signed [31:0] field_y,
  input  logic               last_pair,
  input  logic [30:0]        threshold,
  output desc_t              desc,
  output logic               desc_push,
  input  logic               desc_full
);

  logic               adv;
  // stage 1
  logic               v1;
  logic signed [31:0] sx1, sy1, ex1, ey1, fx1, fy1;
  logic               last1;
  // stage 2
  logic               v2;
  logic signed [32:0] dx2, dy2;
  logic signed [34:0] s2x2, s2y2;
  logic [31:0]        ux2, uy2, tt2;
  logic               small2, last2;
  // stage 3
  logic               v3;
  logic [32:0]        udx3, udy3;
  logic               dxn3, dyn3;
  logic signed [34:0] s2x3, s2y3;
  logic [63:0]        sqa3, sqb3, ttsq3;
  logic               small3, last3;
  // stage 2 logic
  logic signed [32:0] dx_c, dy_c;
  logic signed [34:0] s2x_c, s2y_c;
  logic [34:0]        ux_c, uy_c;
  logic [31:0]        tt_c;
  logic [64:0]        dsum;

  assign adv       = !v3 || !desc_full;
  assign full      = !adv;
  assign desc_push = v3 && !desc_full;

  // differences and doubled midpoint offset
  always_comb begin
    dx_c  = {ex1[31], ex1} - {sx1[31], sx1};
    dy_c  = {ey1[31], ey1} - {sy1[31], sy1};
    s2x_c = {{3{sx1[31]}}, sx1} + {{3{ex1[31]}}, ex1} - {{2{fx1[31]}}, fx1, 1'b0};
    s2y_c = {{3{sy1[31]}}, sy1} + {{3{ey1[31]}}, ey1} - {{2{fy1[31]}}, fy1, 1'b0};
    ux_c  = s2x_c[34] ? 35'(-s2x_c) : 35'(s2x_c);
    uy_c  = s2y_c[34] ? 35'(-s2y_c) : 35'(s2y_c);
    tt_c  = {threshold, 1'b0};
  end

  // squared distance against squared threshold
  always_comb begin
    dsum              = {1'b0, sqa3} + {1'b0, sqb3};
    desc.udx          = udx3;
    desc.dx_neg       = dxn3;
    desc.udy          = udy3;
    desc.dy_neg       = dyn3;
    desc.s2x          = s2x3;
    desc.s2y          = s2y3;
    desc.singular     = small3 && (dsum <= {1'b0, ttsq3});
    desc.last         = last3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= push;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      sx1    <= seg_start_x;
      sy1    <= seg_start_y;
      ex1    <= seg_end_x;
      ey1    <= seg_end_y;
      fx1    <= field_x;
      fy1    <= field_y;
      last1  <= last_pair;
      dx2    <= dx_c;
      dy2    <= dy_c;
      s2x2   <= s2x_c;
      s2y2   <= s2y_c;
      ux2    <= ux_c[31:0];
      uy2    <= uy_c[31:0];
      tt2    <= tt_c;
      small2 <= (ux_c <= {3'b000, tt_c}) && (uy_c <= {3'b000, tt_c});
      last2  <= last1;
      udx3   <= dx2[32] ? 33'(-dx2) : 33'(dx2);
      udy3   <= dy2[32] ? 33'(-dy2) : 33'(dy2);
      dxn3   <= dx2[32];
      dyn3   <= dy2[32];
      s2x3   <= s2x2;
      s2y3   <= s2y2;
      sqa3   <= {32'd0, ux2} * {32'd0, ux2};
      sqb3   <= {32'd0, uy2} * {32'd0, uy2};
      ttsq3  <= {32'd0, tt2} * {32'd0, tt2};
      small3 <= small2;
      last3  <= last2;
    end
  end

endmodule

// ----- rtl/bem2d_fifo.sv -----
// short descriptor queue between front end and back end
// depends on bem2d_pkg for the descriptor type and depth
module bem2d_fifo import bem2d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  desc_t wr_data,
  output logic  full,
  input  logic  rd_en,
  output desc_t rd_data,
  output logic  empty
);

  desc_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/bem2d_back.sv -----
// back end: sequencer over shared multiply, normalize, sqrt, log and reciprocal units
// depends on bem2d_pkg; drains the descriptor queue, holds the result word
module bem2d_back import bem2d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  desc_t              fifo_desc,
  input  logic               fifo_empty,
  output logic               fifo_pop,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] single_layer,
  output logic signed [31:0] double_layer_x,
  output logic signed [31:0] double_layer_y,
  output logic               singular_used,
  output logic               saturated,
  output logic               last
);

  localparam int RND_SH = ACC_FRAC - RESULT_FRAC_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_SS, S_NORM, S_DLSQ, S_SQI, S_SQR, S_DLD, S_SG1, S_LN, S_SG2,
    S_SG3, S_SG4, S_PT, S_R2, S_PX, S_PY, S_C1, S_C2, S_G1, S_G2, S_G3,
    S_DIV, S_H1, S_H2, S_H3, S_H4, S_H5, S_NEXT, S_FIN
  } state_t;

  state_t state, ret;
  desc_t  d;
  logic [2:0] l;
  logic [1:0] j;
  pf_t dl, c, r2, px, py, inv, k2dl, mr, nr, mul_a, mul_b, qin;
  // normalizer
  logic [63:0]             nm;
  logic signed [EXP_W-1:0] ne;
  logic                    nneg;
  // sum of squares
  logic [35:0]             sa, sb;
  logic signed [EXP_W-1:0] se;
  logic [63:0]             ss_sum;
  // square root
  logic [63:0]             sq_v, sq_res, sq_bit, sq_m;
  logic signed [EXP_W-1:0] sq_e, sq_ee;
  // log2
  logic [31:0]             lx, ly, ly_next;
  logic signed [EXP_W-1:0] le;
  logic [4:0]              lcnt;
  logic [63:0]             l_sq;
  logic signed [31:0]      ln_hi;
  logic signed [63:0]      ln_l2;
  // reciprocal
  logic [31:0]             dv_rem;
  logic [33:0]             dv_q;
  logic [5:0]              dv_cnt;
  logic [32:0]             dv_r2;
  // gauss point offsets
  logic signed [35:0]      d2x, d2y, d2x_c, d2y_c;
  logic [63:0]             prx, pry;
  logic [35:0]             ad2x, ad2y, ad2x_c, ad2y_c;
  // accumulators
  logic signed [63:0]      ag, ax, ay, acc_in, addend;
  logic [64:0]             qv, qk, sadd;
  logic                    sat;
  logic [32:0]             f_g, f_x, f_y;
  logic                    ovalid;

  function automatic pf_t pf_mul(input pf_t a, input pf_t b);
    logic [63:0] p;
    pf_t         r;
    p = {32'd0, a.m} * {32'd0, b.m};
    r = '0;
    if (a.m != '0 && b.m != '0) begin
      r.neg = a.neg ^ b.neg;
      if (p[63]) begin
        r.m = p[63:32];
        r.e = a.e + b.e + EXP_W'(32);
      end else begin
        r.m = p[62:31];
        r.e = a.e + b.e + EXP_W'(31);
      end
    end
    return r;
  endfunction

  // {clipped, signed q32 value}
  function automatic logic [64:0] to_q32(input pf_t p);
    logic signed [EXP_W-1:0] sh;
    logic [EXP_W-1:0]        nsh;
    logic [63:0]             mag;
    logic                    s;
    sh  = p.e + EXP_W'(ACC_FRAC);
    nsh = EXP_W'(-sh);
    s   = 1'b0;
    mag = '0;
    if (p.m == '0) begin
      mag = '0;
    end else if (sh > EXP_W'(31)) begin
      s   = 1'b1;
      mag = 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (sh >= 0) begin
      mag = {32'd0, p.m} << sh[4:0];
    end else if (sh <= -EXP_W'(64)) begin
      mag = '0;
    end else begin
      mag = {32'd0, p.m} >> nsh[5:0];
    end
    return {s, (p.neg ? -mag : mag)};
  endfunction

  // {clipped, saturating sum}
  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 64'h8000_0000_0000_0000} : {1'b1, 64'h7FFF_FFFF_FFFF_FFFF};
    end
    return {1'b0, s[63:0]};
  endfunction

  // {clipped, rounded q result}
  function automatic logic [32:0] finish(input logic signed [63:0] acc);
    logic [63:0] mag;
    logic [64:0] rnd;
    logic        s;
    mag = acc[63] ? 64'(-acc) : 64'(acc);
    rnd = ({1'b0, mag} + (65'd1 << (RND_SH - 1))) >> RND_SH;
    s   = 1'b0;
    if (!acc[63] && rnd > 65'h7FFF_FFFF) begin
      s   = 1'b1;
      rnd = 65'h7FFF_FFFF;
    end
    if (acc[63] && rnd > 65'h8000_0000) begin
      s   = 1'b1;
      rnd = 65'h8000_0000;
    end
    return {s, (acc[63] ? 32'(-rnd) : rnd[31:0])};
  endfunction

  assign fifo_pop = (state == S_IDLE) && !fifo_empty;
  assign empty    = !ovalid;
  assign j        = (l < 3'd3) ? l[1:0] : 2'(3'd5 - l);

  // normalizer output view
  always_comb begin
    nr = '0;
    if (nm != '0) begin
      nr.neg = nneg;
      nr.e   = ne;
      nr.m   = nm[31:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DLD:   begin mul_a = nr;   mul_b = INV2PI_PF;     end
      S_SG2:   begin mul_a = nr;   mul_b = LN2_PF;        end
      S_SG3:   begin mul_a = k2dl; mul_b = mr;            end
      S_PY:    begin mul_a = WEIGHT_PF[j]; mul_b = dl;    end
      S_C1:    begin mul_a = mr;   mul_b = INV4PI_PF;     end
      S_G1:    begin mul_a = nr;   mul_b = LN2_PF;        end
      S_G2:    begin mul_a = c;    mul_b = mr;            end
      S_H1:    begin mul_a = c;    mul_b = px;            end
      S_H2:    begin mul_a = mr;   mul_b = inv;           end
      S_H3:    begin mul_a = c;    mul_b = py;            end
      S_H4:    begin mul_a = mr;   mul_b = inv;           end
      default: begin mul_a = '0;   mul_b = '0;            end
    endcase
  end

  // sum of squares, sqrt prep, log step, reciprocal step
  always_comb begin
    ss_sum  = ({33'd0, sa[30:0]} * {33'd0, sa[30:0]}) + ({33'd0, sb[30:0]} * {33'd0, sb[30:0]});
    sq_m    = nr.e[0] ? {31'd0, nr.m, 1'b0} : {32'd0, nr.m};
    sq_ee   = nr.e - EXP_W'(nr.e[0]);
    l_sq    = {32'd0, lx} * {32'd0, lx};
    ly_next = {ly[30:0], l_sq[63]};
    ln_hi   = {{(32-EXP_W){le[EXP_W-1]}}, le} + 32'sd31;
    ln_l2   = {ln_hi, ly_next};
    dv_r2   = {dv_rem, 1'b0};
  end

  // gauss node position relative to the field point
  always_comb begin
    prx    = {34'd0, NODE_Q[j]} * {31'd0, d.udx};
    pry    = {34'd0, NODE_Q[j]} * {31'd0, d.udy};
    d2x_c  = ((l < 3'd3) ^ d.dx_neg) ? ({d.s2x[34], d.s2x} - {3'd0, prx[62:30]})
                                      : ({d.s2x[34], d.s2x} + {3'd0, prx[62:30]});
    d2y_c  = ((l < 3'd3) ^ d.dy_neg) ? ({d.s2y[34], d.s2y} - {3'd0, pry[62:30]})
                                      : ({d.s2y[34], d.s2y} + {3'd0, pry[62:30]});
    ad2x_c = d2x_c[35] ? 36'(-d2x_c) : 36'(d2x_c);
    ad2y_c = d2y_c[35] ? 36'(-d2y_c) : 36'(d2y_c);
    ad2x   = d2x[35] ? 36'(-d2x) : 36'(d2x);
    ad2y   = d2y[35] ? 36'(-d2y) : 36'(d2y);
  end

  // term conversion and accumulation
  always_comb begin
    qin = mr;
    unique case (state)
      S_G3:       qin.e   = mr.e - EXP_W'(1);
      S_H3, S_H5: qin.neg = ~mr.neg;
      default:    qin     = mr;
    endcase
    qv = to_q32(qin);
    qk = to_q32(k2dl);
    unique case (state)
      S_SG4:   begin acc_in = qv[63:0]; addend = -qk[63:0]; end
      S_G3:    begin acc_in = ag;       addend = qv[63:0];  end
      S_H3:    begin acc_in = ax;       addend = qv[63:0];  end
      S_H5:    begin acc_in = ay;       addend = qv[63:0];  end
      default: begin acc_in = '0;       addend = '0;        end
    endcase
    sadd = sat_add(acc_in, addend);
    f_g  = finish(ag);
    f_x  = finish(ax);
    f_y  = finish(ay);
  end

  always_ff @(posedge clk) begin
    mr <= pf_mul(mul_a, mul_b);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ret    <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      if (pop && ovalid && state != S_FIN) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!fifo_empty) begin
            d     <= fifo_desc;
            sa    <= {3'd0, fifo_desc.udx};
            sb    <= {3'd0, fifo_desc.udy};
            se    <= -EXP_W'(2 * COORD_FRAC_BITS);
            ret   <= S_DLSQ;
            ag    <= '0;
            ax    <= '0;
            ay    <= '0;
            sat   <= 1'b0;
            l     <= '0;
            state <= S_SS;
          end
        end
        // common right shift until both operands fit 31 bits
        S_SS: begin
          if (sa[35:31] != '0 || sb[35:31] != '0) begin
            sa <= sa >> 1;
            sb <= sb >> 1;
            se <= se + EXP_W'(2);
          end else begin
            nm    <= ss_sum;
            ne    <= se;
            nneg  <= 1'b0;
            state <= S_NORM;
          end
        end
        // coarse then fine normalize steps
        S_NORM: begin
          if (nm[63:40] != '0) begin
            nm <= nm >> 8;
            ne <= ne + EXP_W'(8);
          end else if (nm[63:32] != '0) begin
            nm <= nm >> 1;
            ne <= ne + EXP_W'(1);
          end else if (nm != '0 && nm[31:23] == '0) begin
            nm <= nm << 8;
            ne <= ne - EXP_W'(8);
          end else if (nm != '0 && !nm[31]) begin
            nm <= nm << 1;
            ne <= ne - EXP_W'(1);
          end else begin
            state <= ret;
          end
        end
        S_DLSQ: begin
          if (nr.m == '0) begin
            state <= S_DLD;
          end else begin
            sq_v   <= sq_m << 30;
            sq_e   <= (sq_ee - EXP_W'(30)) >>> 1;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            state  <= S_SQI;
          end
        end
        S_SQI: begin
          if (sq_bit > sq_v) begin
            sq_bit <= sq_bit >> 2;
          end else begin
            state <= S_SQR;
          end
        end
        // integer square root, one result bit per cycle
        S_SQR: begin
          if (sq_bit == '0) begin
            nm    <= sq_res;
            ne    <= sq_e;
            nneg  <= 1'b0;
            ret   <= S_DLD;
            state <= S_NORM;
          end else begin
            if (sq_v >= sq_res + sq_bit) begin
              sq_v   <= sq_v - (sq_res + sq_bit);
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_DLD: begin
          dl <= nr;
          if (d.singular) begin
            state <= (nr.m == '0) ? S_FIN : S_SG1;
          end else begin
            state <= S_PT;
          end
        end
        // analytic single layer: ln of half length
        S_SG1: begin
          k2dl  <= mr;
          lx    <= dl.m;
          le    <= dl.e - EXP_W'(1);
          ly    <= '0;
          lcnt  <= '0;
          ret   <= S_SG2;
          state <= S_LN;
        end
        // log2 by repeated squaring, one bit per cycle
        S_LN: begin
          lx   <= l_sq[63] ? l_sq[63:32] : l_sq[62:31];
          ly   <= ly_next;
          lcnt <= lcnt + 1'b1;
          if (lcnt == 5'd31) begin
            nm    <= ln_l2[63] ? 64'(-ln_l2) : 64'(ln_l2);
            ne    <= -EXP_W'(32);
            nneg  <= ln_l2[63];
            state <= S_NORM;
          end
        end
        S_SG2: state <= S_SG3;
        S_SG3: state <= S_SG4;
        S_SG4: begin
          ag    <= sadd[63:0];
          sat   <= sat | qv[64] | qk[64] | sadd[64];
          state <= S_FIN;
        end
        // gauss point offset and its squared distance
        S_PT: begin
          d2x   <= d2x_c;
          d2y   <= d2y_c;
          sa    <= ad2x_c;
          sb    <= ad2y_c;
          se    <= -EXP_W'(2 * (COORD_FRAC_BITS + 1));
          ret   <= S_R2;
          state <= S_SS;
        end
        S_R2: begin
          r2 <= nr;
          if (nr.m == '0) begin
            sat   <= 1'b1;
            state <= S_NEXT;
          end else begin
            nm    <= {28'd0, ad2x};
            ne    <= -EXP_W'(COORD_FRAC_BITS + 1);
            nneg  <= d2x[35];
            ret   <= S_PX;
            state <= S_NORM;
          end
        end
        S_PX: begin
          px    <= nr;
          nm    <= {28'd0, ad2y};
          ne    <= -EXP_W'(COORD_FRAC_BITS + 1);
          nneg  <= d2y[35];
          ret   <= S_PY;
          state <= S_NORM;
        end
        S_PY: begin
          py    <= nr;
          state <= S_C1;
        end
        S_C1: state <= S_C2;
        S_C2: begin
          c     <= mr;
          lx    <= r2.m;
          le    <= r2.e;
          ly    <= '0;
          lcnt  <= '0;
          ret   <= S_G1;
          state <= S_LN;
        end
        S_G1: state <= S_G2;
        S_G2: state <= S_G3;
        S_G3: begin
          ag     <= sadd[63:0];
          sat    <= sat | qv[64] | sadd[64];
          dv_rem <= 32'd1;
          dv_q   <= '0;
          dv_cnt <= '0;
          state  <= S_DIV;
        end
        // 2^63 / m, restoring, one quotient bit per cycle
        S_DIV: begin
          if (dv_r2 >= {1'b0, r2.m}) begin
            dv_rem <= 32'(dv_r2 - {1'b0, r2.m});
            dv_q   <= {dv_q[32:0], 1'b1};
          end else begin
            dv_rem <= dv_r2[31:0];
            dv_q   <= {dv_q[32:0], 1'b0};
          end
          dv_cnt <= dv_cnt + 1'b1;
          if (dv_cnt == 6'd62) begin
            nm    <= {30'd0, dv_q[32:0], (dv_r2 >= {1'b0, r2.m})};
            ne    <= -EXP_W'(63) - r2.e;
            nneg  <= 1'b0;
            ret   <= S_H1;
            state <= S_NORM;
          end
        end
        S_H1: begin
          inv   <= nr;
          state <= S_H2;
        end
        S_H2: state <= S_H3;
        S_H3: begin
          ax    <= sadd[63:0];
          sat   <= sat | qv[64] | sadd[64];
          state <= S_H4;
        end
        S_H4: state <= S_H5;
        S_H5: begin
          ay    <= sadd[63:0];
          sat   <= sat | qv[64] | sadd[64];
          state <= S_NEXT;
        end
        S_NEXT: begin
          if (l == 3'd5) begin
            state <= S_FIN;
          end else begin
            l     <= l + 1'b1;
            state <= S_PT;
          end
        end
        // round, clip and hand over the result word
        S_FIN: begin
          if (!ovalid || pop) begin
            single_layer   <= f_g[31:0];
            double_layer_x <= f_x[31:0];
            double_layer_y <= f_y[31:0];
            singular_used  <= d.singular;
            saturated      <= sat | f_g[32] | f_x[32] | f_y[32];
            last           <= d.last;
            ovalid         <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/laplace_2d_boundary_element_quadrature_top.sv -----
// Integrates the 2d Laplace Green's function and its gradient over a straight
// segment for one field point per input word, by 6-point Gauss-Legendre
// quadrature, with the analytic single layer when the segment midpoint lies
// within singular_threshold of the field point. Words enter through a queue
// style push/full port and results leave through empty/pop. A three stage
// front end classifies each pair and parks it in a two entry queue; the back
// end then works through it with a bit-serial square root, log2 and
// reciprocal: a regular pair runs the log2 and the reciprocal at each of the
// six Gauss points, a singular pair only one log2. The front end keeps taking
// words until the queue is full and its last stage holds a pair, and a
// finished result waits in its output register while the next pair is worked
// on; that pair's result is held back until the first one is popped.
// depends on bem2d_pkg, bem2d_front, bem2d_fifo, bem2d_back
module laplace_2d_boundary_element_quadrature_top import bem2d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] seg_start_x,
  input  logic signed [31:0] seg_start_y,
  input  logic signed [31:0] seg_end_x,
  input  logic signed [31:0] seg_end_y,
  input  logic signed [31:0] field_x,
  input  logic signed [31:0] field_y,
  input  logic               last_pair,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] single_layer,
  output logic signed [31:0] double_layer_x,
  output logic signed [31:0] double_layer_y,
  output logic               singular_used,
  output logic               saturated,
  output logic               last
);

  logic [30:0] singular_threshold;
  desc_t       f_desc, q_desc;
  logic        f_push, q_full, q_empty, q_pop;

  // threshold register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      singular_threshold <= 31'd2;
    end else if (cfg_valid && cfg_ready) begin
      singular_threshold <= cfg_data;
    end
  end

  bem2d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .seg_start_x (seg_start_x),
    .seg_start_y (seg_start_y),
    .seg_end_x   (seg_end_x),
    .seg_end_y   (seg_end_y),
    .field_x     (field_x),
    .field_y     (field_y),
    .last_pair   (last_pair),
    .threshold   (singular_threshold),
    .desc        (f_desc),
    .desc_push   (f_push),
    .desc_full   (q_full)
  );

  bem2d_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data (f_desc),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_desc),
    .empty   (q_empty)
  );

  bem2d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .fifo_desc      (q_desc),
    .fifo_empty     (q_empty),
    .fifo_pop       (q_pop),
    .empty          (empty),
    .pop            (pop),
    .single_layer   (single_layer),
    .double_layer_x (double_layer_x),
    .double_layer_y (double_layer_y),
    .singular_used  (singular_used),
    .saturated      (saturated),
    .last           (last)
  );

endmodule
